// ----- rtl/core/countdown_timer_bank_core_defines.svh -----
// -----------------------------------------------------------------------------
// countdown_timer_bank_core_defines.svh
// Assertion macros used by the timer bank checker.
// -----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_BANK_CORE_DEFINES_SVH
`define COUNTDOWN_TIMER_BANK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CTB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define CTB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ctb_pkg.sv -----
// -----------------------------------------------------------------------------
// ctb_pkg
// Types and constants of the countdown timer bank.
// -----------------------------------------------------------------------------
package ctb_pkg;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned LEN_W   = 20;
	localparam int unsigned TICK_W  = 20;
	localparam int unsigned REM_W   = 30;
	localparam int unsigned KIND_W  = 2;

	// Highest number of slots a 4-bit slot field can reach
	localparam int unsigned SLOTS_MAX = 16;

	localparam logic [9:0]        US_PER_MS  = 10'd1000;
	localparam logic [TICK_W-1:0] TICK_RESET = 20'd1000;

	// Request operations
	localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUIET   = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic step;
		logic flush;
	} ctb_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_tick;
		logic out_free;
		logic cur_hit;
		logic pend_valid;
		logic scan_last;
	} ctb_stat_t;

endpackage

// ----- rtl/core/countdown_timer_bank_core.sv -----
// -----------------------------------------------------------------------------
// countdown_timer_bank_core
// Bank of one-shot countdown timers driven by start, stop and tick requests.
// -----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on in_valid/in_ready with op, slot and length_ms.
//    Start loads a slot with length_ms * 1000 us and arms it; stop disarms it.
//    Tick walks all slots in index order, subtracting the tick length from
//    each armed slot or expiring it when its time is used up.
//  - Results leave on out_valid/out_ready: one acknowledge per start or stop,
//    one expiry per expired slot on a tick (last on the final one), or a
//    single quiet result when a tick expires nothing.
//  - Start and stop are answered from the result register in the next cycle.
//  - A tick visits min(NUM_TIMERS, 16) slots in turn, then closes the result;
//    the scan counter over the slot registers walks them.
//  - The tick length is written on cfg_valid/cfg_ready, which is always ready.
//  - Reset disarms every slot and sets the tick length to 1000 us.
//  - A stalled receiver holds the result register; the scan waits on it and
//    no new request is taken until the result register is free.
// -----------------------------------------------------------------------------
module countdown_timer_bank_core import ctb_pkg::*; #(
	parameter int unsigned NUM_TIMERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [TICK_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   op,
	input  logic [SLOT_W-1:0] slot,
	input  logic [LEN_W-1:0]  length_ms,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] kind,
	output logic [SLOT_W-1:0] expired_slot,
	output logic              last
);

	ctb_cmd_t  cmd;
	ctb_stat_t stat;

	// Tick length register takes every write
	assign cfg_ready = 1'b1;

	ctb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ctb_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.op           (op),
		.slot         (slot),
		.length_ms    (length_ms),
		.out_ready    (out_ready),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.kind         (kind),
		.expired_slot (expired_slot),
		.last         (last)
	);

endmodule

// ----- rtl/core/ctb_ctrl.sv -----
// -----------------------------------------------------------------------------
// ctb_ctrl
// Sequencer of the timer bank: accepts requests and walks the slots on a tick.
// -----------------------------------------------------------------------------
module ctb_ctrl import ctb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ctb_stat_t stat,
	output ctb_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t state_q;

	// Take a request only when idle and the result register can take its answer
	assign in_ready = (state_q == ST_IDLE) && stat.out_free;

	// Stall a step only when an expiry must push out the one held back
	always_comb begin
		cmd.accept = in_valid && in_ready;
		cmd.step   = (state_q == ST_SCAN) &&
		             (!(stat.cur_hit && stat.pend_valid) || stat.out_free);
		cmd.flush  = (state_q == ST_FLUSH) && stat.out_free;
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && stat.is_tick) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmd.step && stat.scan_last) state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (cmd.flush) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/ctb_dp.sv -----
// -----------------------------------------------------------------------------
// ctb_dp
// Datapath of the timer bank: slot registers, tick length, scan counter,
// held-back expiry and the result register.
// -----------------------------------------------------------------------------
module ctb_dp import ctb_pkg::*; #(
	parameter int unsigned NUM_TIMERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [TICK_W-1:0] cfg_data,
	input  logic [OP_W-1:0]   op,
	input  logic [SLOT_W-1:0] slot,
	input  logic [LEN_W-1:0]  length_ms,
	input  logic              out_ready,
	input  ctb_cmd_t          cmd,
	output ctb_stat_t         stat,
	output logic              out_valid,
	output logic [KIND_W-1:0] kind,
	output logic [SLOT_W-1:0] expired_slot,
	output logic              last
);

	localparam int unsigned DEPTH = (NUM_TIMERS < SLOTS_MAX) ? NUM_TIMERS : SLOTS_MAX;
	localparam int unsigned CNT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [TICK_W-1:0] tick_len_q;
	logic [REM_W-1:0]  rem_q [DEPTH];
	logic [DEPTH-1:0]  act_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pend_valid_q;
	logic [CNT_W-1:0]  pend_slot_q;
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [SLOT_W-1:0] exp_slot_q;
	logic              last_q;

	logic [CNT_W-1:0] slot_idx;
	logic             slot_ok;
	logic [REM_W-1:0] load_us;
	logic [REM_W-1:0] tick_ext;
	logic [REM_W-1:0] cur_rem;
	logic             cur_act;
	logic             cur_exp;

	// Decode the addressed slot; slots past the bank are acknowledged only
	assign slot_idx = slot[CNT_W-1:0];
	assign slot_ok  = 32'(slot) < DEPTH;

	// Convert milliseconds to microseconds
	assign load_us = REM_W'(length_ms) * REM_W'(US_PER_MS);

	// Look at the slot under the scan counter
	assign tick_ext = REM_W'(tick_len_q);
	assign cur_rem  = rem_q[cnt_q];
	assign cur_act  = act_q[cnt_q];
	assign cur_exp  = !(cur_rem > tick_ext);

	always_comb begin
		stat.is_tick    = (op == OP_TICK);
		stat.out_free   = !out_valid_q || out_ready;
		stat.cur_hit    = cur_act && cur_exp;
		stat.pend_valid = pend_valid_q;
		stat.scan_last  = (cnt_q == CNT_W'(DEPTH - 1));
	end

	// Control registers: tick length, active flags, scan and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_len_q   <= TICK_RESET;
			act_q        <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) tick_len_q <= cfg_data;

			// Drop the result once taken
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;

			if (cmd.accept) begin
				if (op == OP_TICK) begin
					cnt_q        <= '0;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b1;
					if (slot_ok && (op == OP_START)) act_q[slot_idx] <= 1'b1;
					if (slot_ok && (op == OP_STOP))  act_q[slot_idx] <= 1'b0;
				end
			end

			// Advance the scan; an expiry replaces the held-back one
			if (cmd.step) begin
				if (cur_act && cur_exp) begin
					act_q[cnt_q] <= 1'b0;
					pend_valid_q <= 1'b1;
					if (pend_valid_q) out_valid_q <= 1'b1;
				end
				if (!stat.scan_last) cnt_q <= cnt_q + 1'b1;
			end

			if (cmd.flush) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: slot times, held-back slot, result fields
	always_ff @(posedge clk) begin
		if (cmd.accept && (op != OP_TICK)) begin
			kind_q     <= KIND_ACK;
			exp_slot_q <= '0;
			last_q     <= 1'b1;
			if (slot_ok && (op == OP_START)) rem_q[slot_idx] <= load_us;
		end

		if (cmd.step) begin
			if (cur_act) begin
				if (cur_exp) begin
					rem_q[cnt_q] <= '0;
				end else begin
					rem_q[cnt_q] <= cur_rem - tick_ext;
				end
			end
			if (cur_act && cur_exp) begin
				pend_slot_q <= cnt_q;
				if (pend_valid_q) begin
					kind_q     <= KIND_EXPIRED;
					exp_slot_q <= SLOT_W'(pend_slot_q);
					last_q     <= 1'b0;
				end
			end
		end

		// Close the tick: final expiry, or a quiet tick
		if (cmd.flush) begin
			last_q <= 1'b1;
			if (pend_valid_q) begin
				kind_q     <= KIND_EXPIRED;
				exp_slot_q <= SLOT_W'(pend_slot_q);
			end else begin
				kind_q     <= KIND_QUIET;
				exp_slot_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign expired_slot = exp_slot_q;
	assign last         = last_q;

endmodule

// ----- rtl/core/ctb_checker.sv -----
// -----------------------------------------------------------------------------
// ctb_checker
// Port-level checks of the timer bank, bound to the top level.
// -----------------------------------------------------------------------------
`include "countdown_timer_bank_core_defines.svh"

module ctb_checker import ctb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OP_W-1:0]   op,
	input logic              out_valid,
	input logic              out_ready,
	input logic [KIND_W-1:0] kind,
	input logic              last
);

	// Hold a result until it is taken
	`CTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// Answer a start or stop request in the next cycle
	`CTB_ASSERT_NEXT(a_ack_next, in_valid && in_ready && (op != OP_TICK), out_valid && (kind == KIND_ACK) && last, "start or stop not acknowledged")

	// Stop taking requests while a tick scans
	`CTB_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && (op == OP_TICK), !in_ready, "request taken during a tick")

	// Close every acknowledge and quiet tick in a single result
	`CTB_ASSERT_NOW(a_single_last, out_valid && (kind != KIND_EXPIRED), last, "single result without last")

	// Take a request only when the result register can answer it
	`CTB_ASSERT_NOW(a_ready_free, in_ready, !out_valid || out_ready, "request taken over a stalled result")

endmodule

bind countdown_timer_bank_core ctb_checker u_ctb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.last      (last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the countdown timer bank core. A directed table
// opens the run, then random start/stop/tick traffic runs under several tick
// lengths and several patterns of sender gaps and receiver stalls, with one
// long receiver hold-off. Every result is checked against a model of the
// bank kept in this file.
// -----------------------------------------------------------------------------
module testbench;
	import ctb_pkg::*;

	localparam int unsigned SLOTS         = 16;
	localparam int unsigned SETTLE_CYCLES = 48;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_ITEMS   = 28;
	localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] eslot;
		logic              is_last;
	} timer_result_t;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
		bit                typed;
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] eslot;
		logic              is_last;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [TICK_W-1:0] cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [OP_W-1:0]   op;
	logic [SLOT_W-1:0] slot;
	logic [LEN_W-1:0]  length_ms;
	logic              out_valid;
	logic              out_ready;
	logic [KIND_W-1:0] kind;
	logic [SLOT_W-1:0] expired_slot;
	logic              last;

	// Model of the bank
	logic [TICK_W-1:0] tick_us;
	logic [REM_W-1:0]  rem_us [SLOTS];
	logic              armed [SLOTS];

	timer_result_t results_due [$];
	timer_result_t step_out [$];
	stim_row_t     dir_tab [25];

	int  mismatches;
	int  results_seen;
	int  send_idle_pct;
	int  recv_stall_pct;
	logic hold_go;
	logic hold_off;

	countdown_timer_bank_core #(
		.NUM_TIMERS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.slot(slot),
		.length_ms(length_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.expired_slot(expired_slot),
		.last(last)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop
	initial begin
		#10ms;
		$display("testbench failed");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t result %0d: %s", $time, results_seen, msg);
	endtask

	// Advance the bank model by one request and stage the results it causes
	task automatic advance_bank(input logic [OP_W-1:0] o, input logic [SLOT_W-1:0] s,
			input logic [LEN_W-1:0] l);
		timer_result_t r;
		longint unsigned prod;
		step_out.delete();
		if (o == OP_TICK) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (armed[i]) begin
					if (rem_us[i] > REM_W'(tick_us)) begin
						rem_us[i] = rem_us[i] - REM_W'(tick_us);
					end else begin
						rem_us[i] = '0;
						armed[i]  = 1'b0;
						r.kind    = KIND_EXPIRED;
						r.eslot   = SLOT_W'(i);
						r.is_last = 1'b0;
						step_out.push_back(r);
					end
				end
			end
			if (step_out.size() == 0) begin
				r.kind    = KIND_QUIET;
				r.eslot   = '0;
				r.is_last = 1'b1;
				step_out.push_back(r);
			end else begin
				step_out[step_out.size() - 1].is_last = 1'b1;
			end
		end else begin
			if (int'(s) < SLOTS) begin
				if (o == OP_START) begin
					prod      = longint'(l) * longint'(US_PER_MS);
					rem_us[s] = REM_W'(prod);
					armed[s]  = 1'b1;
				end else if (o == OP_STOP) begin
					armed[s] = 1'b0;
				end
			end
			r.kind    = KIND_ACK;
			r.eslot   = '0;
			r.is_last = 1'b1;
			step_out.push_back(r);
		end
	endtask

	// Offer one request, hold it until taken, then book the expected results
	task automatic send_request(input logic [OP_W-1:0] o, input logic [SLOT_W-1:0] s,
			input logic [LEN_W-1:0] l, input bit typed = 1'b0,
			input timer_result_t want = '{KIND_ACK, 4'd0, 1'b1});
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= o;
		slot      <= s;
		length_ms <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		advance_bank(o, s, l);
		if (typed) begin
			results_due.push_back(want);
		end else begin
			foreach (step_out[k]) results_due.push_back(step_out[k]);
		end
	endtask

	task automatic write_tick_len(input logic [TICK_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tick_us = v;
		cfg_valid <= 1'b0;
	endtask

	// Drain all results, then let the scan finish its closing cycles
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Length that mostly expires within a few ticks of the current tick length
	function automatic logic [LEN_W-1:0] short_len();
		int unsigned scale;
		int unsigned rr;
		scale = (int'(tick_us) * 3) / 1000;
		if (scale == 0) scale = 1;
		rr = $urandom_range(0, 9);
		if (rr < 7) return LEN_W'($urandom_range(0, scale));
		else if (rr < 9) return LEN_W'($urandom_range(0, 31));
		else return LEN_W'($urandom);
	endfunction

	// Random traffic: mostly start bursts followed by ticks, some full-bank
	// fills, the rest arbitrary requests
	task automatic run_traffic(input int n);
		int sent;
		int pick;
		int cnt;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				for (int s = 0; s < SLOTS; s++) begin
					send_request(OP_START, SLOT_W'(s),
						($urandom_range(0, 1) == 0) ? LEN_W'(0) : short_len());
				end
				cnt = $urandom_range(1, 3);
				repeat (cnt) send_request(OP_TICK, SLOT_W'($urandom), LEN_W'($urandom));
				sent += SLOTS + cnt;
			end else if (pick < 72) begin
				cnt = $urandom_range(1, 4);
				repeat (cnt) send_request(OP_START, SLOT_W'($urandom), short_len());
				sent += cnt;
				if ($urandom_range(0, 3) == 0) begin
					send_request(OP_STOP, SLOT_W'($urandom), LEN_W'($urandom));
					sent++;
				end
				cnt = $urandom_range(1, 4);
				repeat (cnt) send_request(OP_TICK, SLOT_W'($urandom), LEN_W'($urandom));
				sent += cnt;
			end else begin
				send_request(OP_W'($urandom), SLOT_W'($urandom), LEN_W'($urandom));
				sent++;
			end
		end
	endtask

	// Receiver: check accepted results, then draw the next ready
	initial begin
		timer_result_t want;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
				if (results_due.size() == 0) begin
					flag_mismatch($sformatf("unexpected result kind %0d slot %0d last %0d",
						kind, expired_slot, last));
				end else begin
					want = results_due.pop_front();
					if (kind !== want.kind)
						flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
					if (expired_slot !== want.eslot)
						flag_mismatch($sformatf("expired_slot %0d, want %0d",
							expired_slot, want.eslot));
					if (last !== want.is_last)
						flag_mismatch($sformatf("last %0d, want %0d", last, want.is_last));
				end
				results_seen++;
			end
			out_ready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off, fired once by the stimulus
	initial begin
		hold_off = 1'b0;
		wait (hold_go === 1'b1);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Stimulus
	initial begin
		logic [TICK_W-1:0] tick_plan [8];
		timer_result_t want;
		int send_plan [4];
		int recv_plan [4];

		mismatches     = 0;
		results_seen   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go        = 1'b0;
		tick_us        = TICK_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			rem_us[i] = '0;
			armed[i]  = 1'b0;
		end

		send_plan = '{0, 66, 0, 27};
		recv_plan = '{0, 0, 66, 27};
		tick_plan = '{20'd1, 20'd1000000, 20'hFFFFF, 20'd0, 20'd250,
			TICK_W'($urandom_range(1, 5000)), 20'd1000, 20'd3};

		dir_tab = '{
			'{OP_TICK,  4'd0,  20'd0,       1'b1, KIND_QUIET, 4'd0, 1'b1},
			'{OP_SPARE, 4'd15, 20'hFFFFF,   1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_STOP,  4'd5,  20'd0,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd0,  20'd0,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd15, 20'hFFFFF,   1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd7,  20'd1,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_TICK,  4'd0,  20'd0,       1'b0, KIND_ACK,   4'd0, 1'b0},
			'{OP_START, 4'd3,  20'd2,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd3,  20'd1,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_TICK,  4'd9,  20'hFFFFF,   1'b0, KIND_ACK,   4'd0, 1'b0},
			'{OP_START, 4'd4,  20'd5,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd9,  20'd3,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_STOP,  4'd9,  20'd0,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_TICK,  4'd0,  20'd0,       1'b0, KIND_ACK,   4'd0, 1'b0},
			'{OP_START, 4'd10, 20'd2,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd11, 20'd2,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_TICK,  4'd0,  20'd0,       1'b0, KIND_ACK,   4'd0, 1'b0},
			'{OP_TICK,  4'd0,  20'd0,       1'b0, KIND_ACK,   4'd0, 1'b0},
			'{OP_STOP,  4'd15, 20'd0,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd8,  20'h55555,   1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_START, 4'd12, 20'hAAAAA,   1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_TICK,  4'd0,  20'd0,       1'b0, KIND_ACK,   4'd0, 1'b0},
			'{OP_STOP,  4'd8,  20'd0,       1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_STOP,  4'd12, 20'hFFFFF,   1'b1, KIND_ACK,   4'd0, 1'b1},
			'{OP_TICK,  4'd0,  20'd0,       1'b0, KIND_ACK,   4'd0, 1'b0}
		};

		// Hold every input at a known value through reset
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		op        <= OP_TICK;
		slot      <= '0;
		length_ms <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table at the reset tick length, no idling
		foreach (dir_tab[i]) begin
			want.kind    = dir_tab[i].kind;
			want.eslot   = dir_tab[i].eslot;
			want.is_last = dir_tab[i].is_last;
			send_request(dir_tab[i].op, dir_tab[i].slot, dir_tab[i].len,
				dir_tab[i].typed, want);
		end
		settle();

		// Random phases across tick lengths and idling patterns
		foreach (tick_plan[p]) begin
			write_tick_len(tick_plan[p]);
			send_idle_pct  = send_plan[p % 4];
			recv_stall_pct = recv_plan[p % 4];
			run_traffic(PHASE_ITEMS);
			settle();
		end

		// Back-pressure: receiver holds off while requests keep coming
		write_tick_len(TICK_RESET);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go <= 1'b1;
		run_traffic(30);
		settle();

		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
